FILE: hdl/servo_pwm_generator_top_macros.svh
// Assertion macros used by the servo pulse generator checker.
`ifndef SERVO_PWM_GENERATOR_TOP_MACROS_SVH
`define SERVO_PWM_GENERATOR_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, for properties that must also hold during reset.
`define SPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/spg_pkg.sv
// Types, constants and width arithmetic of the servo pulse generator.
`default_nettype none
package spg_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned KIND_BITS    = 4;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned WIDTH_W = 17;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned PULSE_W = 4;

  localparam logic [ANGLE_W-1:0] LIMIT_180 = 16'h7FFF;
  localparam int unsigned CLOCK_HZ  = 16000000;
  localparam int unsigned PRESCALE  = 15;
  localparam int unsigned UPDATE_MS = 62;
  localparam int unsigned ONE_MS_RST_INT = (CLOCK_HZ / PRESCALE) / 1000;
  localparam int unsigned PERIOD_RST_INT = UPDATE_MS * ONE_MS_RST_INT;

  localparam logic [KIND_BITS-1:0] KINDS_RST  = 4'd10;
  localparam logic [MS_W-1:0]      ONE_MS_RST = MS_W'(ONE_MS_RST_INT);
  localparam logic [WIDTH_W-1:0]   PERIOD_RST = WIDTH_W'(PERIOD_RST_INT);

  localparam int unsigned SHIFT_180 = 15;
  localparam int unsigned SHIFT_360 = 16;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_KINDS  = 2'd0,
    REG_ONE_MS = 2'd1,
    REG_PERIOD = 2'd2
  } reg_e;

  typedef struct packed {
    logic               accepted;
    logic [PULSE_W-1:0] pulses;
    logic [WIDTH_W-1:0] pulse_width;
  } spg_result_t;

  function automatic logic [ANGLE_W-1:0] angle_reset(input int unsigned c);
    logic [ANGLE_W-1:0] a;
    case (c)
      0:       a = 16'h0000;
      1:       a = 16'h6000;
      2:       a = 16'h7FFF;
      3:       a = 16'h3FFF;
      default: a = '0;
    endcase
    return a;
  endfunction

  // one_ms + (angle * one_ms) >> 15 or 16, saturated to 17 bits
  function automatic logic [WIDTH_W-1:0] width_calc(input logic [ANGLE_W-1:0] angle,
                                                    input logic [MS_W-1:0]    one_ms,
                                                    input logic               kind180);
    logic [ANGLE_W+MS_W-1:0] prod;
    logic [WIDTH_W-1:0]      scaled;
    logic [WIDTH_W:0]        sum;
    prod   = (ANGLE_W + MS_W)'(angle) * (ANGLE_W + MS_W)'(one_ms);
    scaled = kind180 ? WIDTH_W'(prod >> SHIFT_180) : WIDTH_W'(prod >> SHIFT_360);
    sum    = (WIDTH_W + 1)'(one_ms) + (WIDTH_W + 1)'(scaled);
    return sum[WIDTH_W] ? WIDTH_MAX : sum[WIDTH_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/spg_channel.sv
// One servo channel: stored angle and its registered pulse width.
`default_nettype none
module spg_channel
  import spg_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [ANGLE_W-1:0] wr_angle_i,
  input  wire logic [MS_W-1:0]    one_ms_d_i,
  input  wire logic               kind_d_i,
  output      logic [WIDTH_W-1:0] width_d_o,
  output      logic [WIDTH_W-1:0] width_q_o
);

  localparam logic KIND_RST_BIT = (IDX < KIND_BITS) ? KINDS_RST[IDX % KIND_BITS] : 1'b0;

  logic [ANGLE_W-1:0] angle_q, angle_d;
  logic [WIDTH_W-1:0] width_q;

  assign angle_d   = wr_en_i ? wr_angle_i : angle_q;
  // width follows next-state angle and config, so the registered width is never stale
  assign width_d_o = width_calc(angle_d, one_ms_d_i, kind_d_i);
  assign width_q_o = width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= angle_reset(IDX);
      width_q <= width_calc(angle_reset(IDX), ONE_MS_RST, KIND_RST_BIT);
    end else begin
      angle_q <= angle_d;
      width_q <= width_d_o;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/spg_out_buf.sv
// Result register with skid stage for the output stream.
`default_nettype none
module spg_out_buf
  import spg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire spg_result_t in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      spg_result_t out_data_o
);

  logic        out_valid_q, skid_valid_q;
  spg_result_t out_data_q, skid_data_q;
  logic        take;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign take        = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (take) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (in_valid_i) begin
        if (!out_valid_q || take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) out_data_q <= skid_data_q;
    end else if (in_valid_i) begin
      if (!out_valid_q || take) out_data_q <= in_data_i;
      else                      skid_data_q <= in_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/servo_pwm_generator_top.sv
// Top level of the four-channel servo pulse generator.
//
// Each transaction on the input stream is either a timer tick (tuser = 0) or a
// set-angle request (tuser = 1) for one channel. A tick steps the period
// counter, which wraps to zero after period_ticks; on the wrap all servo
// outputs go high, and each output drops once the counter equals its channel's
// pulse width. A set-angle request is refused on a 180-degree channel when the
// angle exceeds 0x7FFF, otherwise the angle is stored. Pulse width is
// one_ms_ticks + (angle * one_ms_ticks) >> 15 (180-degree) or >> 16
// (360-degree), saturated to 17 bits. Every input transaction yields exactly
// one output transaction carrying the accepted flag, the output levels after
// the item and the width of the addressed channel.
// Rate: one item per clock unless the output stalls; path: input register,
// then the result register. Each channel holds its width in a register that
// is recomputed by that channel's own 16x16 multiplier whenever the angle or
// the configuration changes. The result register has a skid stage, so the
// input side keeps taking items while one result waits for the downstream.
// Configuration is written through the APB port: channel_kinds at 0x0,
// one_ms_ticks at 0x4, period_ticks at 0x8.
`default_nettype none
module servo_pwm_generator_top
  import spg_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // [1:0] channel, [17:2] angle, rest zero
  input  wire logic        s_axis_tuser_i,  // [0] op
  // output stream
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [23:0] m_axis_tdata_o,  // [3:0] pulses, [20:4] pulse_width, rest zero
  output      logic        m_axis_tuser_o,  // [0] accepted
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int unsigned LW = (CHANNELS > PULSE_W) ? CHANNELS : PULSE_W;

  // ---- configuration registers ----
  logic [KIND_BITS-1:0] kinds_q, kinds_d;
  logic [MS_W-1:0]      one_ms_q, one_ms_d;
  logic [WIDTH_W-1:0]   period_q, period_d;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    kinds_d  = kinds_q;
    one_ms_d = one_ms_q;
    period_d = period_q;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_KINDS:  kinds_d  = pwdata[KIND_BITS-1:0];
        REG_ONE_MS: one_ms_d = pwdata[MS_W-1:0];
        REG_PERIOD: period_d = pwdata[WIDTH_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KINDS:  prdata = 32'(kinds_q);
      REG_ONE_MS: prdata = 32'(one_ms_q);
      REG_PERIOD: prdata = 32'(period_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_q  <= KINDS_RST;
      one_ms_q <= ONE_MS_RST;
      period_q <= PERIOD_RST;
    end else begin
      kinds_q  <= kinds_d;
      one_ms_q <= one_ms_d;
      period_q <= period_d;
    end
  end

  // ---- input register ----
  logic               s1_valid_q;
  op_e                s1_op_q;
  logic [CH_W-1:0]    s1_ch_q;
  logic [ANGLE_W-1:0] s1_angle_q;
  logic               buf_ready, fire, s_take;

  assign fire            = s1_valid_q && buf_ready;
  assign s_axis_tready_o = !s1_valid_q || fire;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      s1_op_q    <= op_e'(s_axis_tuser_i);
      s1_ch_q    <= s_axis_tdata_i[CH_W-1:0];
      s1_angle_q <= s_axis_tdata_i[CH_W+ANGLE_W-1:CH_W];
    end
  end

  // ---- set-angle check ----
  logic ch_present, set_ok, accepted;

  assign ch_present = (32'(s1_ch_q) < CHANNELS);
  assign set_ok     = ch_present && !(kinds_q[s1_ch_q] && (s1_angle_q > LIMIT_180));
  assign accepted   = (s1_op_q == OP_TICK) || set_ok;

  // ---- channel lanes ----
  logic [WIDTH_W-1:0] width_d [CHANNELS];
  logic [WIDTH_W-1:0] width_q [CHANNELS];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    logic kind_d;
    logic wr_en;
    if (c < KIND_BITS) begin : g_kind
      assign kind_d = kinds_d[c];
    end else begin : g_nokind
      assign kind_d = 1'b0;   // channels past the kind bits are 360-degree
    end
    assign wr_en = fire && (s1_op_q == OP_SET) && set_ok && (32'(s1_ch_q) == c);

    spg_channel #(.IDX(c)) u_ch (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en),
      .wr_angle_i (s1_angle_q),
      .one_ms_d_i (one_ms_d),
      .kind_d_i   (kind_d),
      .width_d_o  (width_d[c]),
      .width_q_o  (width_q[c])
    );
  end

  // ---- period counter and output levels ----
  logic [WIDTH_W-1:0]  count_q, count_d, count_step;
  logic [CHANNELS-1:0] levels_q, levels_d;
  logic                tick;

  assign tick       = fire && (s1_op_q == OP_TICK);
  assign count_step = (count_q >= period_q) ? '0 : count_q + WIDTH_W'(1);

  always_comb begin
    count_d  = count_q;
    levels_d = levels_q;
    if (tick) begin
      count_d = count_step;
      if (count_step == '0) levels_d = '1;
      // a width of zero coincides with the wrap, so that output stays low
      for (int c = 0; c < CHANNELS; c++) begin
        if (width_q[c] == count_step) levels_d[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      levels_q <= '0;
    end else begin
      count_q  <= count_d;
      levels_q <= levels_d;
    end
  end

  // ---- result ----
  spg_result_t res, res_out;
  logic [LW-1:0] levels_ext;

  assign levels_ext = LW'(levels_d);

  always_comb begin
    res.accepted    = accepted;
    res.pulses      = levels_ext[PULSE_W-1:0];
    res.pulse_width = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (32'(s1_ch_q) == c) res.pulse_width = width_d[c];
    end
  end

  spg_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (buf_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res_out)
  );

  assign m_axis_tdata_o = {3'b000, res_out.pulse_width, res_out.pulses};
  assign m_axis_tuser_o = res_out.accepted;

endmodule
`default_nettype wire

FILE: hdl/spg_checker.sv
// Port-level checks of the servo pulse generator, bound to its top level.
`default_nettype none
`include "servo_pwm_generator_top_macros.svh"
module spg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        pready
);

  logic s_txn;
  assign s_txn = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result holds its contents
  `SPG_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "output changed while stalled")
  // with nothing waiting on the output, the input side must be open
  `SPG_ASSERT(a_ready_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with empty output")
  // an accepted transaction is followed by a valid result (its own or an older one)
  `SPG_ASSERT(a_latency, s_txn |=> ##1 m_axis_tvalid_o, "no result two cycles after input")
  // the APB port never inserts wait states, reset or not
  `SPG_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind servo_pwm_generator_top spg_checker u_spg_checker (.*);
`default_nettype wire
